### sv/psds_pkg.sv
// shared types, constants and helpers for the segment projection block
`default_nettype none
package psds_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int IN_BITS        = 16;
	localparam int REG_BITS       = 12;
	localparam int CFG_IDX_BITS   = 8;
	localparam int Z_BITS         = 15;
	localparam int CZ_BITS        = REG_BITS + Z_BITS;
	localparam int PF_BITS        = 28;
	localparam int DIV_BITS       = 28;
	localparam int NUM_BITS       = DIV_BITS + 1;

	localparam logic [REG_BITS-1:0] FOCAL_RESET    = 12'd250;
	localparam logic [REG_BITS-1:0] CENTER_X_RESET = 12'd400;
	localparam logic [REG_BITS-1:0] CENTER_Y_RESET = 12'd300;

	// shade = 255 - trunc(3*z/10); zero from this depth on
	localparam logic signed [IN_BITS-1:0] SHADE_CUT = 16'sd850;
	localparam logic [14:0] SHADE_RECIP = 15'd19662;
	localparam logic [7:0] SHADE_MAX = 8'd255;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FOCAL    = 8'd0,
		REG_CENTER_X = 8'd1,
		REG_CENTER_Y = 8'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CZ_BITS-1:0]        cz;
		logic signed [PF_BITS-1:0] pf;
		logic [Z_BITS-1:0]         z;
	} prod_t;

	typedef struct packed {
		logic [Z_BITS-1:0]   rem;
		logic [DIV_BITS-1:0] work;
		logic [Z_BITS-1:0]   z;
		logic                neg;
	} div_t;

	typedef struct packed {
		prod_t [3:0] lane;
		logic        vis;
		logic [7:0]  shade;
	} prod_item_t;

	typedef struct packed {
		div_t [3:0] lane;
		logic       vis;
		logic [7:0] shade;
	} div_item_t;

	// one restoring division step: one quotient bit
	function automatic div_t div_step(div_t d);
		logic [Z_BITS:0] t;
		logic            ge;
		div_t            r;
		t = {d.rem, d.work[DIV_BITS-1]};
		ge = (t >= {1'b0, d.z});
		r = d;
		r.rem = ge ? Z_BITS'(t - {1'b0, d.z}) : t[Z_BITS-1:0];
		r.work = {d.work[DIV_BITS-2:0], ge};
		return r;
	endfunction

	function automatic logic [7:0] calc_shade(logic signed [IN_BITS-1:0] z);
		logic [24:0] p;
		p = z[9:0] * SHADE_RECIP;
		if (z <= 0)
			return SHADE_MAX;
		else if (z >= SHADE_CUT)
			return 8'd0;
		else
			return SHADE_MAX - p[23:16];
	endfunction

endpackage
`default_nettype wire

### sv/psds_cfg_if.sv
// register write channel
`default_nettype none
interface psds_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [psds_pkg::CFG_IDX_BITS-1:0] index;
	logic [psds_pkg::REG_BITS-1:0]     data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/psds_seg_if.sv
// segment request channel
`default_nettype none
interface psds_seg_if;
	logic                valid;
	logic                ready;
	logic signed [15:0] first_x;
	logic signed [15:0] first_y;
	logic signed [15:0] first_z;
	logic signed [15:0] second_x;
	logic signed [15:0] second_y;
	logic signed [15:0] second_z;
	modport source(output valid, first_x, first_y, first_z, second_x, second_y, second_z,
		input ready);
	modport sink(input valid, first_x, first_y, first_z, second_x, second_y, second_z,
		output ready);
endinterface
`default_nettype wire

### sv/psds_proj_if.sv
// projected segment result channel
`default_nettype none
interface psds_proj_if #(parameter int COORD_BITS = psds_pkg::COORD_BITS_DEF);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] screen_x1;
	logic signed [COORD_BITS-1:0] screen_y1;
	logic signed [COORD_BITS-1:0] screen_x2;
	logic signed [COORD_BITS-1:0] screen_y2;
	logic                         visible;
	logic [7:0]                   shade;
	logic                         saturated;
	modport source(output valid, screen_x1, screen_y1, screen_x2, screen_y2, visible, shade,
		saturated, input ready);
	modport sink(input valid, screen_x1, screen_y1, screen_x2, screen_y2, visible, shade,
		saturated, output ready);
endinterface
`default_nettype wire

### sv/project_segment_with_depth_shade.sv
// Projects a segment's two endpoints to the screen and derives a depth shade.
// One segment enters per cycle unless a stalled output has filled the pipeline.
// The stages are the multiplies, the numerators, a pipelined restoring divider
// (one quotient bit per stage, four lanes), and one output stage for sign, clamp
// and masking. Each stage holds its own valid bit and moves up when the next one
// is free, so bubbles close under a stalled output. Register writes are taken at
// any time but should only be made while no segment is in flight.
`default_nettype none
module project_segment_with_depth_shade #(
	parameter int COORD_BITS = psds_pkg::COORD_BITS_DEF
) (
	input  wire          clk,
	input  wire          arst_n,
	psds_cfg_if.sink     cfg,
	psds_seg_if.sink     seg,
	psds_proj_if.source  proj
);
	import psds_pkg::*;

	localparam int NST  = DIV_BITS + 3;
	localparam int WIDE = ((COORD_BITS > NUM_BITS) ? COORD_BITS : NUM_BITS) + 1;

	logic [REG_BITS-1:0] focal_q, cx_q, cy_q;
	logic [NST-1:0]      vld_q;
	logic [NST:0]        adv;

	prod_item_t          p_s1;
	div_item_t           div_s [0:DIV_BITS];
	logic signed [COORD_BITS-1:0] crd_s3 [0:3];
	logic                vis_s3, sat_s3;
	logic [7:0]          shade_s3;

	prod_item_t          p_d;
	div_item_t           n_d;
	logic signed [COORD_BITS-1:0] crd_d [0:3];
	logic [3:0]          sat_d;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q <= FOCAL_RESET;
			cx_q <= CENTER_X_RESET;
			cy_q <= CENTER_Y_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FOCAL:    focal_q <= cfg.data;
				REG_CENTER_X: cx_q <= cfg.data;
				REG_CENTER_Y: cy_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// a stage moves when it is empty or its successor moves
	always_comb begin
		adv[NST] = proj.ready;
		for (int i = NST - 1; i >= 0; i--)
			adv[i] = !vld_q[i] || adv[i+1];
	end
	assign seg.ready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0])
				vld_q[0] <= seg.valid;
			for (int i = 1; i < NST; i++)
				if (adv[i])
					vld_q[i] <= vld_q[i-1];
		end
	end

	// stage 1: products
	always_comb begin
		logic signed [IN_BITS-1:0] c [0:3];
		logic signed [IN_BITS-1:0] z [0:3];
		logic [REG_BITS-1:0]       ctr [0:3];
		logic signed [PF_BITS:0]   pf;
		c[0] = seg.first_x;  c[1] = seg.first_y;  c[2] = seg.second_x; c[3] = seg.second_y;
		z[0] = seg.first_z;  z[1] = seg.first_z;  z[2] = seg.second_z; z[3] = seg.second_z;
		ctr[0] = cx_q; ctr[1] = cy_q; ctr[2] = cx_q; ctr[3] = cy_q;
		for (int k = 0; k < 4; k++) begin
			pf = c[k] * $signed({1'b0, focal_q});
			p_d.lane[k].cz = ctr[k] * z[k][Z_BITS-1:0];
			p_d.lane[k].pf = pf[PF_BITS-1:0];
			p_d.lane[k].z = z[k][Z_BITS-1:0];
		end
		p_d.vis = (seg.first_z > 0) && (seg.second_z > 0);
		p_d.shade = calc_shade(seg.first_z);
	end

	always_ff @(posedge clk)
		if (adv[0])
			p_s1 <= p_d;

	// stage 2: numerator, sign and magnitude
	always_comb begin
		logic signed [NUM_BITS-1:0] num;
		logic signed [NUM_BITS-1:0] pfx;
		for (int k = 0; k < 4; k++) begin
			pfx = NUM_BITS'(p_s1.lane[k].pf);
			// x lanes add, y lanes subtract
			if (k % 2 == 0)
				num = $signed({2'b00, p_s1.lane[k].cz}) + pfx;
			else
				num = $signed({2'b00, p_s1.lane[k].cz}) - pfx;
			n_d.lane[k].neg = num[NUM_BITS-1];
			n_d.lane[k].work = num[NUM_BITS-1] ? DIV_BITS'(-num) : num[DIV_BITS-1:0];
			n_d.lane[k].rem = '0;
			n_d.lane[k].z = p_s1.lane[k].z;
		end
		n_d.vis = p_s1.vis;
		n_d.shade = p_s1.shade;
	end

	always_ff @(posedge clk)
		if (adv[1])
			div_s[0] <= n_d;

	// divider stages
	for (genvar j = 1; j <= DIV_BITS; j++) begin : g_div
		always_ff @(posedge clk)
			if (adv[j+1]) begin
				for (int k = 0; k < 4; k++)
					div_s[j].lane[k] <= div_step(div_s[j-1].lane[k]);
				div_s[j].vis <= div_s[j-1].vis;
				div_s[j].shade <= div_s[j-1].shade;
			end
	end

	// output stage: sign, clamp, mask
	always_comb begin
		logic signed [NUM_BITS-1:0] sv;
		logic signed [WIDE-1:0]     ext, hi, lo;
		hi = $signed({{(WIDE-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}});
		lo = ~hi;
		for (int k = 0; k < 4; k++) begin
			sv = div_s[DIV_BITS].lane[k].neg ? -$signed({1'b0, div_s[DIV_BITS].lane[k].work})
				: $signed({1'b0, div_s[DIV_BITS].lane[k].work});
			ext = WIDE'(sv);
			sat_d[k] = 1'b0;
			if (ext > hi) begin
				ext = hi;
				sat_d[k] = 1'b1;
			end else if (ext < lo) begin
				ext = lo;
				sat_d[k] = 1'b1;
			end
			crd_d[k] = div_s[DIV_BITS].vis ? ext[COORD_BITS-1:0] : '0;
		end
	end

	always_ff @(posedge clk)
		if (adv[NST-1]) begin
			for (int k = 0; k < 4; k++)
				crd_s3[k] <= crd_d[k];
			vis_s3 <= div_s[DIV_BITS].vis;
			sat_s3 <= div_s[DIV_BITS].vis && (|sat_d);
			shade_s3 <= div_s[DIV_BITS].shade;
		end

	assign proj.valid = vld_q[NST-1];
	assign proj.screen_x1 = crd_s3[0];
	assign proj.screen_y1 = crd_s3[1];
	assign proj.screen_x2 = crd_s3[2];
	assign proj.screen_y2 = crd_s3[3];
	assign proj.visible = vis_s3;
	assign proj.shade = shade_s3;
	assign proj.saturated = sat_s3;

endmodule
`default_nettype wire

### sv/psds_check.sv
// port-level checks for the segment projection block
`default_nettype none
module psds_check #(
	parameter int COORD_BITS = psds_pkg::COORD_BITS_DEF
) (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         out_valid,
	input wire                         out_ready,
	input wire signed [COORD_BITS-1:0] x1,
	input wire signed [COORD_BITS-1:0] y1,
	input wire signed [COORD_BITS-1:0] x2,
	input wire signed [COORD_BITS-1:0] y2,
	input wire                         visible,
	input wire                         saturated
);
	localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(x1) && $stable(y1)
			&& $stable(x2) && $stable(y2) && $stable(visible) && $stable(saturated))
		else $error("stalled result changed");

	a_hidden_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !visible |-> x1 == 0 && y1 == 0 && x2 == 0 && y2 == 0 && !saturated)
		else $error("hidden segment has coordinates");

	a_sat_vis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> visible)
		else $error("saturation on hidden segment");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> x1 == CMAX || x1 == CMIN || y1 == CMAX || y1 == CMIN
			|| x2 == CMAX || x2 == CMIN || y2 == CMAX || y2 == CMIN)
		else $error("saturation without a clamped coordinate");

endmodule

bind project_segment_with_depth_shade psds_check #(.COORD_BITS(COORD_BITS)) u_psds_check (
	.clk(clk), .arst_n(arst_n), .out_valid(proj.valid), .out_ready(proj.ready),
	.x1(proj.screen_x1), .y1(proj.screen_y1), .x2(proj.screen_x2), .y2(proj.screen_y2),
	.visible(proj.visible), .saturated(proj.saturated)
);
`default_nettype wire

### verif/project_segment_with_depth_shade_tb.sv
// self-checking testbench for the segment projection block
`timescale 1ns / 100ps
`default_nettype none
module project_segment_with_depth_shade_tb;
	import psds_pkg::*;

	localparam int CB = COORD_BITS_DEF;

	typedef struct packed {
		logic signed [15:0] x1, y1, z1, x2, y2, z2;
	} seg_t;

	typedef struct packed {
		logic signed [CB-1:0] sx1, sy1, sx2, sy2;
		logic                 vis;
		logic [7:0]           shade;
		logic                 sat;
	} proj_t;

	typedef struct {
		seg_t  s;
		bit    known;
		proj_t p;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	psds_cfg_if  cfg();
	psds_seg_if  seg();
	psds_proj_if #(.COORD_BITS(CB)) proj();

	project_segment_with_depth_shade #(.COORD_BITS(CB)) u_dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .seg(seg), .proj(proj)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	logic [11:0] focal, cen_x, cen_y;
	proj_t       pending_proj[$];
	int          errors = 0;
	int          send_idle_pct = 0, recv_idle_pct = 0;
	int          hold_cycles = 0;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	function automatic logic signed [CB-1:0] clamp(input longint v, inout bit sat);
		longint hi, lo;
		hi = (longint'(1) << (CB - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			v = hi;
			sat = 1;
		end
		if (v < lo) begin
			v = lo;
			sat = 1;
		end
		return v[CB-1:0];
	endfunction

	function automatic proj_t project_segment(input seg_t s);
		proj_t  r;
		bit     sat;
		longint sh;
		sat = 0;
		r = '0;
		r.vis = (s.z1 > 0) && (s.z2 > 0);
		if (r.vis) begin
			// numerators exact in 64 bits; longint division truncates toward zero
			r.sx1 = clamp((longint'(cen_x) * s.z1 + longint'(s.x1) * longint'(focal)) / s.z1,
				sat);
			r.sy1 = clamp((longint'(cen_y) * s.z1 - longint'(s.y1) * longint'(focal)) / s.z1,
				sat);
			r.sx2 = clamp((longint'(cen_x) * s.z2 + longint'(s.x2) * longint'(focal)) / s.z2,
				sat);
			r.sy2 = clamp((longint'(cen_y) * s.z2 - longint'(s.y2) * longint'(focal)) / s.z2,
				sat);
		end
		sh = 255 - (3 * longint'(s.z1)) / 10;
		if (sh < 0) sh = 0;
		if (sh > 255) sh = 255;
		r.shade = sh[7:0];
		r.sat = sat;
		return r;
	endfunction

	// result side
	always @(posedge clk) begin
		proj_t g, w;
		if (proj.valid && proj.ready) begin
			g = '{proj.screen_x1, proj.screen_y1, proj.screen_x2, proj.screen_y2,
				proj.visible, proj.shade, proj.saturated};
			if (pending_proj.size() == 0) begin
				report("unexpected result", 0, 0);
			end else begin
				w = pending_proj.pop_front();
				if (g.sx1 !== w.sx1) report("screen_x1", g.sx1, w.sx1);
				if (g.sy1 !== w.sy1) report("screen_y1", g.sy1, w.sy1);
				if (g.sx2 !== w.sx2) report("screen_x2", g.sx2, w.sx2);
				if (g.sy2 !== w.sy2) report("screen_y2", g.sy2, w.sy2);
				if (g.vis !== w.vis) report("visible", g.vis, w.vis);
				if (g.shade !== w.shade) report("shade", g.shade, w.shade);
				if (g.sat !== w.sat) report("saturated", g.sat, w.sat);
			end
		end
	end

	// receiver back-pressure, with a counted long hold
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proj.ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			proj.ready <= 1'b0;
		end else begin
			proj.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [11:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		unique case (idx)
			REG_FOCAL:    focal = val;
			REG_CENTER_X: cen_x = val;
			REG_CENTER_Y: cen_y = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_proj.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// one request; valid stays high across back-to-back requests
	task automatic send(input seg_t s, input bit known, input proj_t p);
		proj_t e;
		while ($urandom_range(99) < send_idle_pct) begin
			seg.valid <= 1'b0;
			@(posedge clk);
		end
		seg.valid <= 1'b1;
		{seg.first_x, seg.first_y, seg.first_z, seg.second_x, seg.second_y,
			seg.second_z} <= s;
		e = project_segment(s);
		do @(posedge clk); while (!seg.ready);
		pending_proj.push_back(known ? p : e);
	endtask

	function automatic logic signed [15:0] rnd_coord();
		case ($urandom_range(5))
			0: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
			1, 2: return $signed(16'($urandom_range(400))) - 16'sd200;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [15:0] rnd_depth();
		case ($urandom_range(9))
			0: return 16'sd0;
			1: return 16'($urandom);
			2: return $signed(16'($urandom_range(1000))) - 16'sd500;
			3: return 16'sd1;
			default: return 16'($urandom_range(32767, 1));
		endcase
	endfunction

	function automatic seg_t rnd_seg();
		seg_t s;
		s.x1 = rnd_coord();
		s.y1 = rnd_coord();
		s.x2 = rnd_coord();
		s.y2 = rnd_coord();
		s.z1 = rnd_depth();
		s.z2 = rnd_depth();
		return s;
	endfunction

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) send(rnd_seg(), 0, '0);
		seg.valid <= 1'b0;
	endtask

	dir_row_t dir_rows[$];

	initial begin
		proj_t z;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		seg.valid = 1'b0;
		{seg.first_x, seg.first_y, seg.first_z, seg.second_x, seg.second_y,
			seg.second_z} = '0;
		focal = FOCAL_RESET;
		cen_x = CENTER_X_RESET;
		cen_y = CENTER_Y_RESET;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// known rows: origin projects to the center, hidden segments give zeros
		z = '0;
		dir_rows.push_back('{'{0, 0, 10, 0, 0, 10}, 1,
			'{16'sd400, 16'sd300, 16'sd400, 16'sd300, 1'b1, 8'd252, 1'b0}});
		dir_rows.push_back('{'{5, 5, 0, 5, 5, 10}, 1,
			'{0, 0, 0, 0, 1'b0, 8'd255, 1'b0}});
		dir_rows.push_back('{'{5, 5, 10, 5, 5, -1}, 1,
			'{0, 0, 0, 0, 1'b0, 8'd252, 1'b0}});
		dir_rows.push_back('{'{5, 5, -32768, 5, 5, 5}, 1,
			'{0, 0, 0, 0, 1'b0, 8'd255, 1'b0}});
		dir_rows.push_back('{'{16'sh7fff, 16'sh7fff, 1, 16'sh8000, 16'sh8000, 1}, 1,
			'{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b1, 8'd255, 1'b1}});
		dir_rows.push_back('{'{0, 0, 32767, 0, 0, 32767}, 1,
			'{16'sd400, 16'sd300, 16'sd400, 16'sd300, 1'b1, 8'd0, 1'b0}});
		dir_rows.push_back('{'{1, 2, 849, 3, 4, 850}, 0, z});
		dir_rows.push_back('{'{1, 2, 851, 3, 4, 853}, 0, z});
		dir_rows.push_back('{'{-7, 9, 3, 7, -9, 3}, 0, z});
		dir_rows.push_back('{'{16'sh8000, 16'sh7fff, 32767, 16'sh7fff, 16'sh8000, 32767}, 0, z});
		dir_rows.push_back('{'{-1, -1, 1, 1, 1, 2}, 0, z});
		dir_rows.push_back('{'{100, -100, 9, -100, 100, 11}, 0, z});
		foreach (dir_rows[i]) send(dir_rows[i].s, dir_rows[i].known, dir_rows[i].p);
		seg.valid <= 1'b0;
		drain();

		write_reg(REG_FOCAL, 12'd0);
		write_reg(REG_CENTER_X, 12'd4095);
		write_reg(REG_CENTER_Y, 12'd0);
		dir_rows.delete();
		dir_rows.push_back('{'{16'sh7fff, 16'sh8000, 7, 3, 3, 1}, 1,
			'{16'sd4095, 16'sd0, 16'sd4095, 16'sd0, 1'b1, 8'd253, 1'b0}});
		foreach (dir_rows[i]) send(dir_rows[i].s, dir_rows[i].known, dir_rows[i].p);
		seg.valid <= 1'b0;
		random_phase(60);
		drain();

		write_reg(REG_FOCAL, 12'd4095);
		write_reg(REG_CENTER_X, 12'd0);
		write_reg(REG_CENTER_Y, 12'd4095);
		send_idle_pct = 9;
		recv_idle_pct = 85;
		random_phase(450);
		drain();

		// long receiver hold while requests keep coming
		hold_cycles = 200;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(150);
		drain();

		write_reg(REG_FOCAL, 12'($urandom_range(4095, 1)));
		write_reg(REG_CENTER_X, 12'($urandom));
		write_reg(REG_CENTER_Y, 12'($urandom));
		send_idle_pct = 85;
		recv_idle_pct = 9;
		random_phase(450);
		drain();

		write_reg(REG_FOCAL, FOCAL_RESET);
		write_reg(REG_CENTER_X, CENTER_X_RESET);
		write_reg(REG_CENTER_Y, CENTER_Y_RESET);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(250);
		// sender waits for every outstanding result, then continues
		while (pending_proj.size() != 0) @(posedge clk);
		random_phase(250);
		drain();

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire

### project_segment_with_depth_shade.f
sv/psds_pkg.sv
sv/psds_cfg_if.sv
sv/psds_seg_if.sv
sv/psds_proj_if.sv
sv/project_segment_with_depth_shade.sv
sv/psds_check.sv
verif/project_segment_with_depth_shade_tb.sv
